### rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared constants, codes and types of the linear probing hash set core.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int TABLE_SIZE = 251;
   localparam int KEY_W      = 31;
   localparam int CMD_W      = 2;
   localparam int OCC_W      = 8;
   localparam int ST_W       = 2;
   localparam int BKT_W      = $clog2(TABLE_SIZE);
   localparam int RAM_W      = ST_W + KEY_W;

   // remainder unit: bits of the key consumed per cycle
   localparam int MOD_DIGITS = 8;
   localparam int MOD_CYCLES = (KEY_W + MOD_DIGITS - 1) / MOD_DIGITS;
   localparam int MOD_PAD_W  = MOD_CYCLES * MOD_DIGITS;
   localparam int MOD_CNT_W  = $clog2(MOD_CYCLES + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

   localparam logic [ST_W-1:0] ST_UNUSED  = 2'd0;
   localparam logic [ST_W-1:0] ST_USING   = 2'd1;
   localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [BKT_W-1:0] home;
   } lphs_entry_type;

endpackage

### rtl/lphs_ram.sv
// ----------------------------------------------------------------------------
// lphs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lphs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lphs_front.sv
// ----------------------------------------------------------------------------
// lphs_front
// Accepts request words and works out the home bucket, key modulo table size,
// with a digit serial remainder, then hands the entry to the queue.
// ----------------------------------------------------------------------------
module lphs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lphs_pkg::CMD_W-1:0] req_cmd,
   input  logic [lphs_pkg::KEY_W-1:0] req_key,
   output logic                       q_push,
   output lphs_pkg::lphs_entry_type   q_entry,
   input  logic                       q_full
);
   import lphs_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MOD  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   localparam logic [BKT_W:0] MODULUS = (BKT_W + 1)'(TABLE_SIZE);

   logic [1:0]           state_ff, state_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [MOD_PAD_W-1:0] key_sh_ff, key_sh_in;
   logic [BKT_W-1:0]     rem_ff, rem_in;
   logic [BKT_W:0]       rem_step;

   // remainder over one group of key bits, msb first
   always_comb begin
      rem_step = {1'b0, rem_ff};
      for (int i = 0; i < MOD_DIGITS; i++) begin
         rem_step = {rem_step[BKT_W-1:0], key_sh_ff[MOD_PAD_W-1-i]};
         if (rem_step >= MODULUS) begin
            rem_step = rem_step - MODULUS;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      key_sh_in = key_sh_ff;
      rem_in    = rem_ff;
      q_push    = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               key_sh_in = MOD_PAD_W'(req_key);
               rem_in    = '0;
               cnt_in    = '0;
               state_in  = F_MOD;
            end
         end
         F_MOD: begin
            rem_in    = rem_step[BKT_W-1:0];
            key_sh_in = key_sh_ff << MOD_DIGITS;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == MOD_CNT_W'(MOD_CYCLES - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      key_sh_ff <= key_sh_in;
      rem_ff    <= rem_in;
   end

   assign req_stall    = (state_ff != F_IDLE);
   assign q_entry.cmd  = cmd_ff;
   assign q_entry.key  = key_ff;
   assign q_entry.home = rem_ff;

endmodule

### rtl/lphs_queue.sv
// ----------------------------------------------------------------------------
// lphs_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module lphs_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lphs_pkg::lphs_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output lphs_pkg::lphs_entry_type pop_entry,
   output logic                     empty
);
   import lphs_pkg::*;

   lphs_entry_type     entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full      = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

### rtl/lphs_back.sv
// ----------------------------------------------------------------------------
// lphs_back
// Walks the probe chain one bucket per table read, updates the table and the
// in-use count, and holds the response word until it is taken.
// ----------------------------------------------------------------------------
module lphs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  lphs_pkg::lphs_entry_type   q_entry,
   input  logic                       q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_success,
   output logic [lphs_pkg::OCC_W-1:0] rsp_used_count
);
   import lphs_pkg::*;

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_READ  = 2'd1;
   localparam logic [1:0] B_CHECK = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [BKT_W-1:0]      bkt_ff, bkt_in;
   logic [BKT_W-1:0]      cnt_ff, cnt_in;
   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   logic                  valid_q_ff, valid_q_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_success_ff, rsp_success_in;
   logic [OCC_W-1:0]      rsp_count_ff, rsp_count_in;

   logic             slot_free;
   logic             fin;
   logic             fin_ok;
   logic             lap_end;
   logic [BKT_W-1:0] bkt_next;
   logic [ST_W-1:0]  cur_st;
   logic [KEY_W-1:0] cur_key;
   logic             ram_we;
   logic [RAM_W-1:0] ram_wdata;
   logic             ram_re;
   logic [RAM_W-1:0] ram_rdata;

   lphs_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (bkt_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (bkt_ff),
      .rd_data (ram_rdata)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign lap_end   = (cnt_ff == BKT_W'(TABLE_SIZE - 1));
   assign bkt_next  = (bkt_ff == BKT_W'(TABLE_SIZE - 1)) ? '0 : bkt_ff + 1'b1;
   assign cur_st    = valid_q_ff ? ram_rdata[KEY_W +: ST_W] : ST_UNUSED;
   assign cur_key   = ram_rdata[KEY_W-1:0];

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      bkt_in     = bkt_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff;
      valid_q_in = valid_q_ff;
      occ_in     = occ_ff;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_wdata  = {ST_USING, key_ff};
      ram_re     = 1'b0;
      fin        = 1'b0;
      fin_ok     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop  = 1'b1;
               cmd_in = q_entry.cmd;
               key_in = q_entry.key;
               bkt_in = q_entry.home;
               cnt_in = '0;
               if (q_entry.cmd == CMD_INSERT || q_entry.cmd == CMD_ERASE ||
                   q_entry.cmd == CMD_FIND) begin
                  state_in = B_READ;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         B_READ: begin
            ram_re     = 1'b1;
            valid_q_in = valid_ff[bkt_ff];
            state_in   = B_CHECK;
         end
         B_CHECK: begin
            if (cmd_ff == CMD_INSERT) begin
               if (cur_st != ST_USING) begin
                  ram_we           = 1'b1;
                  ram_wdata        = {ST_USING, key_ff};
                  valid_in[bkt_ff] = 1'b1;
                  occ_in           = occ_ff + 1'b1;
                  fin              = 1'b1;
                  fin_ok           = 1'b1;
               end else if (lap_end) begin
                  fin = 1'b1;
               end
            end else begin
               if (cur_st == ST_USING && cur_key == key_ff) begin
                  fin    = 1'b1;
                  fin_ok = 1'b1;
                  if (cmd_ff == CMD_ERASE) begin
                     ram_we    = 1'b1;
                     ram_wdata = {ST_DELETED, cur_key};
                     occ_in    = occ_ff - 1'b1;
                  end
               end else if (cur_st == ST_UNUSED || lap_end) begin
                  fin = 1'b1;
               end
            end
            if (fin) begin
               state_in = B_IDLE;
            end else begin
               bkt_in   = bkt_next;
               cnt_in   = cnt_ff + 1'b1;
               state_in = B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_success_in = rsp_success_ff;
      rsp_count_in   = rsp_count_ff;
      if (fin) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = fin_ok;
         rsp_count_in   = occ_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      bkt_ff         <= bkt_in;
      cnt_ff         <= cnt_in;
      valid_q_ff     <= valid_q_in;
      rsp_success_ff <= rsp_success_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_used_count = rsp_count_ff;

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      fin |-> !rsp_valid_ff || !rsp_stall)
      else $error("response word overwritten");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != B_IDLE |-> bkt_ff < BKT_W'(TABLE_SIZE))
      else $error("probe bucket out of range");

   a_erase_hits_used: assert property (@(posedge clock) disable iff (reset)
      ram_we && cmd_ff == CMD_ERASE |-> valid_q_ff && cur_st == ST_USING)
      else $error("erase of a bucket not in use");

endmodule

### rtl/linear_probe_hash_set_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Set of 31-bit keys in an open addressed table with linear probing.
// ----------------------------------------------------------------------------
// Each request word (insert, erase or find) yields one response word with the
// success flag and the count of buckets in use. The front takes a word, forms
// the home bucket with a digit serial remainder (eight key bits of remainder
// per cycle) and hands it to the queue once the queue has room, while the back
// works on the word before it. The back dispatches a word and then probes each
// bucket in a table read state and then a compare and update state, so its
// work grows with the number of buckets probed and is bounded by the table
// read port. The bucket status is cleared at reset at once; there is no
// clearing pass.
module linear_probe_hash_set_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lphs_pkg::CMD_W-1:0] req_cmd,
   input  logic [lphs_pkg::KEY_W-1:0] req_key,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_success,
   output logic [lphs_pkg::OCC_W-1:0] rsp_used_count
);
   import lphs_pkg::*;

   lphs_entry_type push_entry;
   lphs_entry_type pop_entry;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   lphs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_key   (req_key),
      .q_push    (q_push),
      .q_entry   (push_entry),
      .q_full    (q_full)
   );

   lphs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   lphs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_entry        (pop_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_success    (rsp_success),
      .rsp_used_count (rsp_used_count)
   );

endmodule

### bench/linear_probe_hash_set_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set_checker
// Watches both channels of the hash set core, keeps its own copy of the
// bucket table, works out the response to every accepted request word and
// compares it field by field with the response words in order. The failure
// count and the number of responses still due go to the test top.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [lphs_pkg::CMD_W-1:0] req_cmd,
   input  logic [lphs_pkg::KEY_W-1:0] req_key,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_success,
   input  logic [lphs_pkg::OCC_W-1:0] rsp_used_count,
   output int                         fail_count,
   output int                         pending
);
   import lphs_pkg::*;

   typedef struct packed {
      logic             success;
      logic [OCC_W-1:0] used_count;
   } set_outcome_type;

   logic [KEY_W-1:0] slot_key [TABLE_SIZE];
   logic [ST_W-1:0]  slot_state [TABLE_SIZE];
   logic [OCC_W-1:0] live_total;
   set_outcome_type  due_outcomes [$];
   int               mismatch_total = 0;
   int               due_total = 0;

   assign fail_count = mismatch_total;
   assign pending    = due_total;

   // bucket holding the key, or -1 when the probe hits an unused bucket or laps
   function automatic int find_slot(input logic [KEY_W-1:0] key);
      int b;
      int n;
      b = int'({1'b0, key} % TABLE_SIZE);
      for (n = 0; n < TABLE_SIZE; n++) begin
         if (slot_state[b] == ST_USING && slot_key[b] == key) return b;
         if (slot_state[b] == ST_UNUSED) return -1;
         b = (b == TABLE_SIZE - 1) ? 0 : b + 1;
      end
      return -1;
   endfunction

   function automatic set_outcome_type apply_set_op(input logic [CMD_W-1:0] cmd,
                                                    input logic [KEY_W-1:0] key);
      set_outcome_type res;
      int              b;
      int              n;
      res.success = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            b = int'({1'b0, key} % TABLE_SIZE);
            for (n = 0; n < TABLE_SIZE && !res.success; n++) begin
               if (slot_state[b] != ST_USING) begin
                  slot_key[b]   = key;
                  slot_state[b] = ST_USING;
                  live_total++;
                  res.success = 1'b1;
               end
               b = (b == TABLE_SIZE - 1) ? 0 : b + 1;
            end
         end
         CMD_ERASE: begin
            b = find_slot(key);
            if (b >= 0) begin
               slot_state[b] = ST_DELETED;
               live_total--;
               res.success = 1'b1;
            end
         end
         CMD_FIND: begin
            res.success = (find_slot(key) >= 0);
         end
         default: begin
         end
      endcase
      res.used_count = live_total;
      return res;
   endfunction

   always @(posedge clock) begin
      set_outcome_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_state[i] = ST_UNUSED;
            slot_key[i]   = '0;
         end
         live_total = '0;
         due_outcomes.delete();
      end else begin
         if (req_valid && !req_stall) due_outcomes.push_back(apply_set_op(req_cmd, req_key));
         if (rsp_valid && !rsp_stall) begin
            if (due_outcomes.size() == 0) begin
               $display("%0t: response word with none expected, success %0d used_count %0d",
                        $time, rsp_success, rsp_used_count);
               mismatch_total++;
            end else begin
               want = due_outcomes.pop_front();
               if (rsp_success !== want.success) begin
                  $display("%0t: success expected %0d actual %0d",
                           $time, want.success, rsp_success);
                  mismatch_total++;
               end
               if (rsp_used_count !== want.used_count) begin
                  $display("%0t: used_count expected %0d actual %0d",
                           $time, want.used_count, rsp_used_count);
                  mismatch_total++;
               end
            end
         end
      end
      due_total = due_outcomes.size();
   end

endmodule

### bench/linear_probe_hash_set_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core_test
// Stimulus and verdict for the linear probing hash set core. A directed run
// over empty table, collisions, duplicates, tombstones, wrap and unknown
// commands, then random words with clustered keys under changing idle rates,
// and then a fill to a full table, a mass erase and more random words.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core_test;
   import lphs_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX     = '1;
   localparam int               CYCLE_LIMIT = 3_000_000;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   logic [CMD_W-1:0] req_cmd        = '0;
   logic [KEY_W-1:0] req_key        = '0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   logic             rsp_success;
   logic [OCC_W-1:0] rsp_used_count;

   int               fail_count;
   int               pending;
   int               send_idle_pct  = 22;
   int               recv_idle_pct  = 87;
   int               cycle_count    = 0;
   logic [KEY_W-1:0] kept_keys [$];

   always #5 clock = ~clock;

   linear_probe_hash_set_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_success    (rsp_success),
      .rsp_used_count (rsp_used_count)
   );

   linear_probe_hash_set_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_success    (rsp_success),
      .rsp_used_count (rsp_used_count),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // clustered homes, live keys, extremes and full range keys
   function automatic logic [KEY_W-1:0] pick_key();
      int          roll;
      logic [31:0] raw;
      roll = $urandom_range(99);
      if (roll < 30 && kept_keys.size() > 0) begin
         return kept_keys[$urandom_range(kept_keys.size() - 1)];
      end
      if (roll < 65) begin
         raw = $urandom_range(2000) * 251 + $urandom_range(15) * 16;
      end else if (roll < 70) begin
         case ($urandom_range(3))
            0:       raw = 32'd0;
            1:       raw = {1'b0, KEY_MAX};
            2:       raw = 32'd250;
            default: raw = 32'd251;
         endcase
      end else begin
         raw = $urandom();
      end
      return raw[KEY_W-1:0];
   endfunction

   task automatic random_word();
      int               roll;
      int               idx;
      logic [KEY_W-1:0] key;
      roll = $urandom_range(99);
      if (roll < ((kept_keys.size() > 120) ? 25 : 40)) begin
         key = pick_key();
         kept_keys.push_back(key);
         send_word(CMD_INSERT, key);
      end else if (roll < 75) begin
         if (kept_keys.size() > 0 && $urandom_range(99) < 80) begin
            idx = $urandom_range(kept_keys.size() - 1);
            key = kept_keys[idx];
            kept_keys.delete(idx);
         end else begin
            key = pick_key();
         end
         send_word(CMD_ERASE, key);
      end else if (roll < 95) begin
         send_word(CMD_FIND, pick_key());
      end else begin
         send_word(CMD_UNKNOWN, pick_key());
      end
   endtask

   initial begin
      logic [31:0]      raw;
      logic [KEY_W-1:0] key;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, collisions at bucket zero, duplicates, tombstones, wrap
      send_word(CMD_FIND, KEY_W'(0));
      send_word(CMD_ERASE, KEY_W'(0));
      send_word(CMD_UNKNOWN, KEY_MAX);
      send_word(CMD_INSERT, KEY_W'(0));
      send_word(CMD_INSERT, KEY_MAX);
      send_word(CMD_INSERT, KEY_W'(251));
      send_word(CMD_INSERT, KEY_W'(0));
      send_word(CMD_FIND, KEY_W'(251));
      send_word(CMD_ERASE, KEY_W'(0));
      send_word(CMD_FIND, KEY_W'(0));
      send_word(CMD_ERASE, KEY_W'(0));
      send_word(CMD_FIND, KEY_W'(0));
      send_word(CMD_ERASE, KEY_W'(0));
      send_word(CMD_INSERT, KEY_W'(502));
      send_word(CMD_INSERT, KEY_W'(250));
      send_word(CMD_INSERT, KEY_W'(501));
      send_word(CMD_FIND, KEY_W'(501));
      send_word(CMD_ERASE, KEY_MAX);
      send_word(CMD_FIND, KEY_MAX);
      send_word(CMD_UNKNOWN, KEY_W'(0));
      send_word(CMD_FIND, KEY_W'(753));

      repeat (360) random_word();
      wait_drained();

      send_idle_pct = 87;
      recv_idle_pct = 22;
      repeat (360) random_word();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (150) random_word();

      // fill until full, then inserts and misses that lap the whole table
      for (int n = 0; n < 253; n++) begin
         raw = $urandom();
         key = raw[KEY_W-1:0];
         kept_keys.push_back(key);
         send_word(CMD_INSERT, key);
      end
      repeat (3) begin
         raw = $urandom();
         send_word(CMD_FIND, raw[KEY_W-1:0]);
      end
      send_word(CMD_FIND, kept_keys[$]);
      raw = $urandom();
      send_word(CMD_INSERT, raw[KEY_W-1:0]);

      // leaves tombstones among used buckets but no unused one, so misses walk a full lap
      repeat (150) send_word(CMD_ERASE, kept_keys.pop_front());
      repeat (30) random_word();

      wait_drained();
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
